// ----- hw/rtl/surface_header_scanner_macros.svh -----
// ----------------------------------------------------------------------------
// Surface header scanner assertion macros
// Shared concurrent assertion forms, clocked on clk_i and off during reset.
// ----------------------------------------------------------------------------
`ifndef SURFACE_HEADER_SCANNER_MACROS_SVH
`define SURFACE_HEADER_SCANNER_MACROS_SVH

// Same-cycle implication.
`define SHS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/shs_pkg.sv -----
// ----------------------------------------------------------------------------
// Surface header scanner package
// Types, register indexes, format codes and scan constants.
// ----------------------------------------------------------------------------
package shs_pkg;

  localparam int unsigned MAX_DIM_DEF    = 4096;
  localparam int unsigned HEADER_GAP_DEF = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned SKIP_W     = 5;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned DIM_OUT_W  = 13;
  localparam int unsigned FMT_W      = 2;
  localparam int unsigned OFS_W      = 32;
  localparam int unsigned SIZE_W     = 26;
  localparam int unsigned WIN_W      = 56;

  localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SURF_LIMIT = 1'b1;

  localparam logic [31:0] TYPE_RGB24  = 32'h0000_1004;
  localparam logic [31:0] TYPE_16_A   = 32'h0000_1006;
  localparam logic [31:0] TYPE_16_B   = 32'h0000_1007;

  localparam logic [FMT_W-1:0] FMT_RGB24 = 2'd0;
  localparam logic [FMT_W-1:0] FMT_16_A  = 2'd1;
  localparam logic [FMT_W-1:0] FMT_16_B  = 2'd2;

  localparam logic [COUNT_W-1:0] MAX_SURF_RESET = 16'd16;

  // header length from the start of the type word and the lag of the type word
  localparam int unsigned HDR_LEN  = 16;
  localparam int unsigned TYPE_LAG = 3;
  localparam logic [31:0] MIN_POS  = 32'd7;

  typedef struct packed {
    logic                 hit;
    logic [FMT_W-1:0]     fmt;
    logic [DIM_OUT_W-1:0] width;
    logic [DIM_OUT_W-1:0] height;
    logic [OFS_W-1:0]     offset;
    logic [SIZE_W-1:0]    size;
  } shs_cand_t;

  typedef struct packed {
    logic                 is_summary;
    logic [COUNT_W-1:0]   count;
    logic [DIM_OUT_W-1:0] width;
    logic [DIM_OUT_W-1:0] height;
    logic [FMT_W-1:0]     fmt;
    logic [OFS_W-1:0]     offset;
    logic [SIZE_W-1:0]    size;
  } shs_rec_t;

endpackage

// ----- hw/rtl/surface_header_scanner.sv -----
// ----------------------------------------------------------------------------
// Surface header scanner
// Finds surface headers in a byte stream and reports one beat per surface
// plus an end-of-file summary beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one file byte per beat (in_data_byte_i, in_is_last_i),
//   taken when in_valid_i is high and in_stall_o is low. Set in_is_last_i
//   on the final byte of each file.
//   Output channel: surface and summary beats, taken when out_valid_o is
//   high and out_stall_i is low.
//   Configuration: write the file size (index 0) and the surface limit
//   (index 1) through cfg_we_i while the scanner is idle.
//   A beat that yields a record passes the input register, then the output
//   register, before it shows on out_valid_o. Throughput: one byte per cycle
//   while the output register is free, set by the single input to result
//   register pass with one 13x13 multiply and a 34-bit add and compare.
//   Reset clears the window, position, skip and surface counts, sets
//   the file size to 0 and the surface limit to 16. The summary beat clears
//   the scan state again for the next file.
//   When out_stall_i holds a full output register, the input register
//   holds its byte and in_stall_o rises.
// ----------------------------------------------------------------------------
`include "surface_header_scanner_macros.svh"

module surface_header_scanner #(
  parameter int unsigned MAX_DIM    = shs_pkg::MAX_DIM_DEF,
  parameter int unsigned HEADER_GAP = shs_pkg::HEADER_GAP_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [shs_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [shs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     in_data_byte_i,
  input  logic                           in_is_last_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           out_is_summary_o,
  output logic [shs_pkg::COUNT_W-1:0]    out_surf_total_o,
  output logic [shs_pkg::DIM_OUT_W-1:0]  out_surface_width_o,
  output logic [shs_pkg::DIM_OUT_W-1:0]  out_surface_height_o,
  output logic [shs_pkg::FMT_W-1:0]      out_pixel_format_o,
  output logic [shs_pkg::OFS_W-1:0]      out_data_offset_o,
  output logic [shs_pkg::SIZE_W-1:0]     out_data_size_o
);
  import shs_pkg::*;

  logic [31:0]      file_size_q;
  logic [31:0]      file_size_d;
  logic [COUNT_W-1:0] max_surf_q;
  logic [COUNT_W-1:0] max_surf_d;

  logic             s1_valid_q;
  logic             s1_valid_d;
  logic [7:0]       s1_byte_q;
  logic             s1_last_q;

  logic [WIN_W-1:0] win_q;
  logic [WIN_W-1:0] win_d;
  logic [31:0]      pos_q;
  logic [31:0]      pos_d;
  logic [SKIP_W-1:0]  skip_q;
  logic [SKIP_W-1:0]  skip_d;
  logic [COUNT_W-1:0] found_q;
  logic [COUNT_W-1:0] found_d;

  logic             in_accept;
  logic             out_free;
  logic             s1_advance;
  logic             scan_ok;
  logic             hit;
  logic             load;
  shs_cand_t        cand;
  shs_rec_t         rec;
  shs_rec_t         rec_out;

  always_comb begin
    file_size_d = file_size_q;
    max_surf_d  = max_surf_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FILE_SIZE:  file_size_d = cfg_wdata_i;
        REG_SURF_LIMIT: max_surf_d  = cfg_wdata_i[COUNT_W-1:0];
        default:        file_size_d = file_size_q;
      endcase
    end
  end

  assign in_stall_o = s1_valid_q && !out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_advance = s1_valid_q && out_free;
  assign s1_valid_d = in_accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_q);

  shs_check #(
    .MAX_DIM(MAX_DIM)
  ) u_check (
    .window_i   (win_q),
    .byte_i     (s1_byte_q),
    .pos_i      (pos_q),
    .file_size_i(file_size_q),
    .cand_o     (cand)
  );

  assign scan_ok = (skip_q == '0) && (pos_q >= MIN_POS) && (found_q < max_surf_q);
  assign hit     = !s1_last_q && scan_ok && cand.hit;
  assign load    = s1_advance && (s1_last_q || hit);

  always_comb begin
    win_d   = win_q;
    pos_d   = pos_q;
    skip_d  = skip_q;
    found_d = found_q;
    if (s1_advance) begin
      if (s1_last_q) begin
        win_d   = '0;
        pos_d   = '0;
        skip_d  = '0;
        found_d = '0;
      end else begin
        win_d = {win_q[WIN_W-9:0], s1_byte_q};
        pos_d = pos_q + 32'd1;
        if (skip_q != '0) begin
          skip_d = skip_q - SKIP_W'(1);
        end else if (hit) begin
          skip_d  = SKIP_W'(HEADER_GAP);
          found_d = found_q + COUNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    if (s1_last_q) begin
      rec            = '0;
      rec.is_summary = 1'b1;
      rec.count      = found_q;
    end else begin
      rec.is_summary = 1'b0;
      rec.count      = found_q + COUNT_W'(1);
      rec.width      = cand.width;
      rec.height     = cand.height;
      rec.fmt        = cand.fmt;
      rec.offset     = cand.offset;
      rec.size       = cand.size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_size_q <= '0;
      max_surf_q  <= MAX_SURF_RESET;
      s1_valid_q  <= 1'b0;
      win_q       <= '0;
      pos_q       <= '0;
      skip_q      <= '0;
      found_q     <= '0;
    end else begin
      file_size_q <= file_size_d;
      max_surf_q  <= max_surf_d;
      s1_valid_q  <= s1_valid_d;
      win_q       <= win_d;
      pos_q       <= pos_d;
      skip_q      <= skip_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= in_data_byte_i;
      s1_last_q <= in_is_last_i;
    end
  end

  shs_out_reg u_out_reg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (load),
    .rec_i  (rec),
    .free_o (out_free),
    .valid_o(out_valid_o),
    .stall_i(out_stall_i),
    .rec_o  (rec_out)
  );

  assign out_is_summary_o     = rec_out.is_summary;
  assign out_surf_total_o     = rec_out.count;
  assign out_surface_width_o  = rec_out.width;
  assign out_surface_height_o = rec_out.height;
  assign out_pixel_format_o   = rec_out.fmt;
  assign out_data_offset_o    = rec_out.offset;
  assign out_data_size_o      = rec_out.size;

  `SHS_ASSERT_SAME(a_stall_needs_item, in_stall_o, s1_valid_q, "stall without held byte")
  `SHS_ASSERT_SAME(a_surf_total_nz, out_valid_o && !out_is_summary_o, out_surf_total_o != '0, "zero total")
  `SHS_ASSERT_NEXT(a_hit_starts_skip, s1_advance && hit, skip_q == SKIP_W'(HEADER_GAP), "skip not armed")
  `SHS_ASSERT_NEXT(a_summary_clears, load && s1_last_q, found_q == '0 && pos_q == '0, "scan state kept")

endmodule

// ----- hw/rtl/shs_check.sv -----
// ----------------------------------------------------------------------------
// Surface header candidate check
// Decodes type, width and height from the byte window, sizes the pixel data
// and bounds it against the file size.
// ----------------------------------------------------------------------------
module shs_check #(
  parameter int unsigned MAX_DIM = shs_pkg::MAX_DIM_DEF
) (
  input  logic [shs_pkg::WIN_W-1:0] window_i,
  input  logic [7:0]                byte_i,
  input  logic [31:0]               pos_i,
  input  logic [31:0]               file_size_i,
  output shs_pkg::shs_cand_t        cand_o
);
  import shs_pkg::*;

  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned PROD_W = 2 * DIM_W;
  localparam int unsigned SUM_W  = ((PROD_W + 2 > 32) ? PROD_W + 2 : 32) + 2;

  logic [15:0]        w;
  logic [15:0]        h;
  logic [31:0]        t;
  logic               type_ok;
  logic               bpp3;
  logic [FMT_W-1:0]   fmt;
  logic               w_ok;
  logic               h_ok;
  logic [PROD_W-1:0]  wh;
  logic [SUM_W-1:0]   wh_ext;
  logic [SUM_W-1:0]   dsize;
  logic [SUM_W-1:0]   ofs;
  logic [SUM_W-1:0]   end_ofs;

  assign w = {window_i[47:40], window_i[55:48]};
  assign h = {window_i[31:24], window_i[39:32]};
  assign t = {byte_i, window_i[7:0], window_i[15:8], window_i[23:16]};

  always_comb begin
    type_ok = 1'b0;
    bpp3    = 1'b0;
    fmt     = FMT_RGB24;
    unique case (t)
      TYPE_RGB24: begin
        type_ok = 1'b1;
        bpp3    = 1'b1;
        fmt     = FMT_RGB24;
      end
      TYPE_16_A: begin
        type_ok = 1'b1;
        fmt     = FMT_16_A;
      end
      TYPE_16_B: begin
        type_ok = 1'b1;
        fmt     = FMT_16_B;
      end
      default: begin
        type_ok = 1'b0;
      end
    endcase
  end

  assign w_ok = (w != '0) && (w <= 16'(MAX_DIM));
  assign h_ok = (h != '0) && (h <= 16'(MAX_DIM));

  assign wh     = w[DIM_W-1:0] * h[DIM_W-1:0];
  assign wh_ext = SUM_W'(wh);
  assign dsize  = bpp3 ? ((wh_ext << 1) + wh_ext) : (wh_ext << 1);

  assign ofs     = SUM_W'(pos_i) + SUM_W'(HDR_LEN - TYPE_LAG);
  assign end_ofs = ofs + dsize;

  always_comb begin
    cand_o.hit    = type_ok && w_ok && h_ok && (end_ofs <= SUM_W'(file_size_i));
    cand_o.fmt    = fmt;
    cand_o.width  = w[DIM_OUT_W-1:0];
    cand_o.height = h[DIM_OUT_W-1:0];
    cand_o.offset = ofs[OFS_W-1:0];
    cand_o.size   = dsize[SIZE_W-1:0];
  end

endmodule

// ----- hw/rtl/shs_out_reg.sv -----
// ----------------------------------------------------------------------------
// Surface header scanner output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module shs_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  shs_pkg::shs_rec_t rec_i,
  output logic              free_o,
  output logic              valid_o,
  input  logic              stall_i,
  output shs_pkg::shs_rec_t rec_o
);
  import shs_pkg::*;

  logic     valid_q;
  logic     valid_d;
  shs_rec_t rec_q;

  assign free_o  = !valid_q || !stall_i;
  assign valid_d = load_i ? 1'b1 : (free_o ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign valid_o = valid_q;
  assign rec_o   = rec_q;

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Surface header scanner testbench
// Streams files of random bytes with embedded surface headers through the
// scanner, with random sender bursts and receiver stalls. The expected
// surface and summary records are computed on every accepted byte and each
// output beat is checked against the oldest one, field by field.
// ----------------------------------------------------------------------------
module tb;
  import shs_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned NUM_BYTES  = 1800;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } scan_beat_t;

  logic                  clk          = 1'b0;
  logic                  rst_n        = 1'b0;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_FILE_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata    = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_data_byte = '0;
  logic                  in_is_last   = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  logic                  out_is_summary;
  logic [COUNT_W-1:0]    out_surf_total;
  logic [DIM_OUT_W-1:0]  out_surface_width;
  logic [DIM_OUT_W-1:0]  out_surface_height;
  logic [FMT_W-1:0]      out_pixel_format;
  logic [OFS_W-1:0]      out_data_offset;
  logic [SIZE_W-1:0]     out_data_size;

  // scan model state and register copies
  logic [WIN_W-1:0]      scan_window   = '0;
  logic [31:0]           scan_pos      = '0;
  logic [SKIP_W-1:0]     skip_cnt      = '0;
  logic [COUNT_W-1:0]    surf_found    = '0;
  logic [31:0]           file_size_cfg = '0;
  logic [COUNT_W-1:0]    max_surf_cfg  = MAX_SURF_RESET;

  shs_rec_t              record_q[$];
  scan_beat_t            byte_q[$];
  scan_beat_t            file_bytes[$];
  scan_beat_t            next_beat;
  shs_rec_t              want;
  int unsigned           bytes_sent    = 0;
  int unsigned           bytes_taken   = 0;
  int unsigned           mismatches    = 0;
  int unsigned           idle_cycles   = 0;
  int unsigned           burst_left    = 16;
  int unsigned           gap_left      = 0;
  logic [5:0]            stall_tick    = '0;
  int unsigned           stall_mode    = 0;

  surface_header_scanner i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .in_data_byte_i      (in_data_byte),
    .in_is_last_i        (in_is_last),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .out_is_summary_o    (out_is_summary),
    .out_surf_total_o    (out_surf_total),
    .out_surface_width_o (out_surface_width),
    .out_surface_height_o(out_surface_height),
    .out_pixel_format_o  (out_pixel_format),
    .out_data_offset_o   (out_data_offset),
    .out_data_size_o     (out_data_size)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void scan_byte(input logic [7:0] b, input logic last);
    logic [63:0]      view;
    logic [15:0]      w;
    logic [15:0]      h;
    logic [31:0]      t;
    logic [31:0]      tpos;
    logic [63:0]      dsize;
    logic [1:0]       bpp;
    logic [FMT_W-1:0] fmt;
    shs_rec_t         rec;
    view = {scan_window, b};
    rec  = '0;
    if (last) begin
      rec.is_summary = 1'b1;
      rec.count      = surf_found;
      record_q.push_back(rec);
      scan_window = '0;
      scan_pos    = '0;
      skip_cnt    = '0;
      surf_found  = '0;
      return;
    end
    w   = {view[55:48], view[63:56]};
    h   = {view[39:32], view[47:40]};
    t   = {view[7:0], view[15:8], view[23:16], view[31:24]};
    bpp = 2'd0;
    fmt = FMT_RGB24;
    if (t == TYPE_RGB24) begin
      bpp = 2'd3;
      fmt = FMT_RGB24;
    end else if (t == TYPE_16_A) begin
      bpp = 2'd2;
      fmt = FMT_16_A;
    end else if (t == TYPE_16_B) begin
      bpp = 2'd2;
      fmt = FMT_16_B;
    end
    if (skip_cnt != 0) begin
      skip_cnt--;
    end else if (scan_pos >= MIN_POS && surf_found < max_surf_cfg && bpp != 0 &&
                 w >= 1 && h >= 1 && w <= MAX_DIM_DEF && h <= MAX_DIM_DEF) begin
      tpos  = scan_pos - TYPE_LAG;
      dsize = 64'(w) * 64'(h) * 64'(bpp);
      if (64'(tpos) + 64'(HDR_LEN) + dsize <= 64'(file_size_cfg)) begin
        surf_found++;
        rec.count  = surf_found;
        rec.width  = w[DIM_OUT_W-1:0];
        rec.height = h[DIM_OUT_W-1:0];
        rec.fmt    = fmt;
        rec.offset = tpos + HDR_LEN;
        rec.size   = dsize[SIZE_W-1:0];
        skip_cnt   = SKIP_W'(HEADER_GAP_DEF);
        record_q.push_back(rec);
      end
    end
    scan_window = view[WIN_W-1:0];
    scan_pos++;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h10;
      1:       return 8'h04;
      2:       return 8'h00;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_dim();
    case ($urandom_range(0, 15))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd4096;
      3:       return 16'd4097;
      4:       return 16'($urandom_range(0, 16'hFFFF));
      5:       return 16'($urandom_range(1, 4096));
      default: return 16'($urandom_range(1, 64));
    endcase
  endfunction

  task automatic put_byte(input logic [7:0] b, input logic last);
    scan_beat_t beat;
    beat.data = b;
    beat.last = last;
    file_bytes.push_back(beat);
  endtask

  task automatic put_type(input logic [31:0] t);
    for (int i = 0; i < 4; i++) put_byte(t[8*i +: 8], 1'b0);
  endtask

  task automatic put_header(input logic [15:0] w, input logic [15:0] h,
                            input logic [31:0] t, output int tpos);
    put_byte(w[7:0], 1'b0);
    put_byte(w[15:8], 1'b0);
    put_byte(h[7:0], 1'b0);
    put_byte(h[15:8], 1'b0);
    tpos = file_bytes.size();
    put_type(t);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    if (idx == REG_FILE_SIZE) file_size_cfg = value;
    else max_surf_cfg = value[COUNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic play_file(input logic [31:0] fs, input logic [15:0] ms,
                           input bit wr_fs, input bit wr_ms);
    while (bytes_taken != bytes_sent || record_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (wr_fs) write_reg(REG_FILE_SIZE, fs);
    if (wr_ms) write_reg(REG_SURF_LIMIT, CFG_DATA_W'(ms));
    put_byte(8'($urandom_range(0, 255)), 1'b1);
    foreach (file_bytes[i]) byte_q.push_back(file_bytes[i]);
    bytes_sent += file_bytes.size();
    file_bytes.delete();
  endtask

  // sender: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        scan_byte(in_data_byte, in_is_last);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          in_valid <= 1'b0;
          gap_left--;
        end else if (byte_q.size() > 0) begin
          next_beat = byte_q.pop_front();
          in_valid     <= 1'b1;
          in_data_byte <= next_beat.data;
          in_is_last   <= next_beat.last;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: gap_left = 0;
              5, 6, 7:       gap_left = $urandom_range(1, 3);
              default:       gap_left = $urandom_range(4, 12);
            endcase
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: check each beat, stall in a mode picked anew each time stall_tick wraps
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (record_q.size() == 0) begin
          $error("unexpected record beat: summary %0d, count %0d",
                 out_is_summary, out_surf_total);
          mismatches++;
        end else begin
          want = record_q.pop_front();
          check_field("is_summary", 32'(want.is_summary), 32'(out_is_summary));
          check_field("surf_total", 32'(want.count), 32'(out_surf_total));
          check_field("surface_width", 32'(want.width), 32'(out_surface_width));
          check_field("surface_height", 32'(want.height), 32'(out_surface_height));
          check_field("pixel_format", 32'(want.fmt), 32'(out_pixel_format));
          check_field("data_offset", want.offset, out_data_offset);
          check_field("data_size", 32'(want.size), 32'(out_data_size));
        end
      end
      if (stall_tick == 0) stall_mode = $urandom_range(0, 3);
      stall_tick++;
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] ms;
    logic [31:0] t;
    logic [31:0] fs;
    logic [63:0] bound;
    bit          have_bound;
    int          tpos;
    int          k;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: file size zero, nothing fits
    put_header(16'd1, 16'd1, TYPE_RGB24, tpos);
    play_file(32'd0, 16'd0, 1'b0, 1'b0);
    // largest surface, widest registers
    put_header(16'd4096, 16'd4096, TYPE_RGB24, tpos);
    play_file(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1);
    // no surfaces allowed; bare type word at the file start
    put_type(TYPE_16_B);
    play_file(32'hFFFF_FFFF, 16'd0, 1'b0, 1'b1);

    while (bytes_sent < NUM_BYTES) begin
      have_bound = 1'b0;
      bound      = '0;
      if ($urandom_range(0, 7) == 0) put_type($urandom_range(0, 1) ? TYPE_16_A : TYPE_RGB24);
      repeat ($urandom_range(0, 6)) put_byte(noise_byte(), 1'b0);
      repeat ($urandom_range(0, 5)) begin
        w = pick_dim();
        h = pick_dim();
        k = $urandom_range(0, 9);
        if (k < 4) t = TYPE_RGB24;
        else if (k < 6) t = TYPE_16_A;
        else if (k < 8) t = TYPE_16_B;
        else if (k == 8) t = TYPE_16_B ^ (32'h1 << $urandom_range(0, 31));
        else t = $urandom;
        put_header(w, h, t, tpos);
        if (!have_bound && (t == TYPE_RGB24 || t == TYPE_16_A || t == TYPE_16_B) &&
            w >= 1 && h >= 1 && w <= MAX_DIM_DEF && h <= MAX_DIM_DEF) begin
          bound = 64'(tpos) + 64'(HDR_LEN) +
                  64'(w) * 64'(h) * ((t == TYPE_RGB24) ? 64'd3 : 64'd2);
          have_bound = 1'b1;
        end
        repeat ($urandom_range(0, 20)) put_byte(noise_byte(), 1'b0);
      end

      k = $urandom_range(0, 9);
      if (k < 5) fs = 32'hFFFF_FFFF;
      else if (k == 5) fs = $urandom;
      else if (k == 6) fs = $urandom_range(0, 16);
      else if (k < 9 && have_bound) fs = bound[31:0] - ((k == 8) ? 32'd1 : 32'd0);
      else fs = $urandom_range(0, 32'h000F_FFFF);

      k = $urandom_range(0, 9);
      if (k < 6) ms = 16'hFFFF;
      else if (k == 6) ms = 16'd0;
      else if (k == 7) ms = 16'($urandom_range(1, 3));
      else if (k == 8) ms = MAX_SURF_RESET;
      else ms = 16'($urandom_range(0, 16'hFFFF));

      play_file(fs, ms, $urandom_range(0, 4) != 0, $urandom_range(0, 4) != 0);
    end

    while (bytes_taken != bytes_sent || record_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/shs_pkg.sv
hw/rtl/shs_check.sv
hw/rtl/shs_out_reg.sv
hw/rtl/surface_header_scanner.sv
tb/tb.sv
